[design/pcsg_pkg.sv]
// Shared constants and the saturation helper for the piecewise cubic setpoint unit.
// No dependencies; imported by pcsg_mac and the top level.
`default_nettype none
package pcsg_pkg;

   localparam int MAX_BREAKPOINTS_DEF = 64;
   localparam int FRACTION_BITS_DEF   = 16;
   localparam int DATA_W              = 32;
   localparam int TICKS_PER_SECOND    = 50;

   // clamp a wide signed value into the 32-bit signed range
   function automatic logic signed [DATA_W-1:0] sat_to_32(
      input logic signed [2*DATA_W:0] v
   );
      logic signed [DATA_W-1:0] r;
      if (v[2*DATA_W:DATA_W-1] == {(DATA_W+2){v[2*DATA_W]}}) begin
         r = v[DATA_W-1:0];
      end else if (v[2*DATA_W]) begin
         r = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(DATA_W-1){1'b1}}};
      end
      return r;
   endfunction

endpackage
`default_nettype wire

[design/pcsg_mac.sv]
// Shared multiply, round and accumulate unit: product register, then round, add, saturate.
// Depends on pcsg_pkg.
`default_nettype none
module pcsg_mac
   import pcsg_pkg::*;
#(
   parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     mul_en,
   input  wire logic signed [DATA_W-1:0] operand,
   input  wire logic        [DATA_W-1:0] time_value,
   input  wire logic signed [DATA_W:0]   addend,
   output logic signed [DATA_W-1:0]      result
);

   localparam int PW = 2 * DATA_W;
   localparam logic signed [PW-1:0] HALF = PW'(64'sd1 <<< (FRACTION_BITS - 1));

   logic signed [DATA_W:0]   op_ext;
   logic signed [DATA_W:0]   t_ext;
   logic signed [PW+1:0]     mul_full;
   logic signed [PW-1:0]     product_in;
   logic signed [PW-1:0]     product_ff;
   logic signed [PW-1:0]     rounded;
   logic signed [PW:0]       sum;

   assign op_ext     = {operand[DATA_W-1], operand};
   assign t_ext      = {1'b0, time_value};
   assign mul_full   = op_ext * t_ext;
   assign product_in = mul_full[PW-1:0];

   always_ff @(posedge clock) begin
      if (mul_en) begin
         product_ff <= product_in;
      end
   end

   // add half then floor
   assign rounded = (product_ff + HALF) >>> FRACTION_BITS;
   assign sum     = {rounded[PW-1], rounded} + {{(PW-DATA_W){addend[DATA_W]}}, addend};
   assign result  = sat_to_32(sum);

endmodule
`default_nettype wire

[design/piecewise_cubic_setpoint_generator_unit.sv]
// Piecewise cubic setpoint generator: tick, start and table load items in, x/y setpoints out.
// Sequence: loads and start complete in idle, and a tick with no result visits only the
// compare state. An emitting tick runs the compare state, then for each axis on the
// shared multiplier a coefficient fetch, then five multiply/accumulate steps.
// Throughput: one item at a time; req_stall low only in idle.
// Result sits in an output register, so the next item is taken while it waits. Synchronous
// reset, no clearing pass.
// Depends on pcsg_pkg and pcsg_mac.
`default_nettype none
module piecewise_cubic_setpoint_generator_unit
   import pcsg_pkg::*;
#(
   parameter int MAX_BREAKPOINTS = MAX_BREAKPOINTS_DEF,
   parameter int FRACTION_BITS   = FRACTION_BITS_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [2:0]               req_mode,
   input  wire logic [7:0]               req_table_index,
   input  wire logic signed [DATA_W-1:0] req_table_value,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic signed [DATA_W-1:0]      rsp_position_x,
   output logic signed [DATA_W-1:0]      rsp_velocity_x,
   output logic signed [DATA_W-1:0]      rsp_position_y,
   output logic signed [DATA_W-1:0]      rsp_velocity_y,
   output logic [5:0]                    rsp_segment_used,
   input  wire logic                     csr_write,
   input  wire logic                     csr_index,
   input  wire logic [DATA_W-1:0]        csr_wdata
);

   localparam int SIW        = $clog2(MAX_BREAKPOINTS);
   localparam int SW         = $clog2(MAX_BREAKPOINTS + 1);
   localparam int COEF_DEPTH = 4 * MAX_BREAKPOINTS;
   localparam int CAW        = SIW + 2;
   localparam int COUNT_W    = 7;
   localparam int SEG_OUT_W  = 6;
   localparam logic [DATA_W-1:0] TICK_RESET =
      DATA_W'(((1 << FRACTION_BITS) + TICKS_PER_SECOND / 2) / TICKS_PER_SECOND);

   localparam logic [2:0] MODE_TICK   = 3'd0;
   localparam logic [2:0] MODE_START  = 3'd1;
   localparam logic [2:0] MODE_LOAD_B = 3'd2;
   localparam logic [2:0] MODE_LOAD_X = 3'd3;
   localparam logic [2:0] MODE_LOAD_Y = 3'd4;

   localparam logic CSR_TICK_STEP = 1'b0;
   localparam logic CSR_BP_COUNT  = 1'b1;

   typedef enum logic [2:0] {
      S_IDLE, S_CMP, S_INIT, S_LOADA, S_MUL, S_ACC, S_OUT
   } state_type;

   typedef enum logic [2:0] {
      STEP_PB, STEP_VB, STEP_PC, STEP_VC, STEP_PD
   } step_type;

   // control registers
   state_type            state_ff, state_in;
   logic [DATA_W-1:0]    tick_step_ff, tick_step_in;
   logic [COUNT_W-1:0]   bp_count_ff, bp_count_in;
   logic [DATA_W-1:0]    elapsed_ff, elapsed_in;
   logic                 armed_ff, armed_in;
   logic [SW-1:0]        seg_ff, seg_in;
   logic [SIW-1:0]       seg_used_ff, seg_used_in;
   logic [1:0]           coef_k_ff, coef_k_in;
   step_type             step_ff, step_in;
   logic                 axis_ff, axis_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // datapath registers
   logic signed [DATA_W-1:0] p_ff, p_in;
   logic signed [DATA_W-1:0] v_ff, v_in;
   logic signed [DATA_W-1:0] hold_px_ff, hold_px_in;
   logic signed [DATA_W-1:0] hold_vx_ff, hold_vx_in;
   logic signed [DATA_W-1:0] rsp_px_ff, rsp_vx_ff, rsp_py_ff, rsp_vy_ff;
   logic [SIW-1:0]           rsp_seg_ff;

   // table storage
   logic [DATA_W-1:0]        bp_mem [MAX_BREAKPOINTS];
   logic signed [DATA_W-1:0] x_mem  [COEF_DEPTH];
   logic signed [DATA_W-1:0] y_mem  [COEF_DEPTH];
   logic [DATA_W-1:0]        bp_rd_ff;
   logic signed [DATA_W-1:0] x_rd_ff, y_rd_ff;

   logic                     req_accept;
   logic                     rsp_free;
   logic                     load_rsp;
   logic [SW-1:0]            count_eff;
   logic [DATA_W:0]          elapsed_sum;
   logic [DATA_W-1:0]        elapsed_tick;
   logic                     passed;
   logic [SW-1:0]            seg_next;
   logic                     bp_wr, x_wr, y_wr;
   logic [CAW-1:0]           coef_rd_addr;
   logic signed [DATA_W-1:0] coef;
   logic signed [DATA_W:0]   mac_addend;
   logic signed [DATA_W-1:0] mac_operand;
   logic signed [DATA_W-1:0] mac_result;
   logic signed [DATA_W-1:0] three_a;
   logic                     step_is_v;
   logic                     step_last;
   step_type                 step_nxt;
   logic [1:0]               coef_k_nxt;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign load_rsp   = (state_ff == S_OUT) && rsp_free;

   // breakpoint count as used: zero reads as one, clamp at the store depth
   always_comb begin
      if (bp_count_ff == '0) begin
         count_eff = SW'(1);
      end else if (32'(bp_count_ff) > MAX_BREAKPOINTS) begin
         count_eff = SW'(MAX_BREAKPOINTS);
      end else begin
         count_eff = SW'(bp_count_ff);
      end
   end

   assign elapsed_sum  = {1'b0, elapsed_ff} + {1'b0, tick_step_ff};
   assign elapsed_tick = elapsed_sum[DATA_W] ? '1 : elapsed_sum[DATA_W-1:0];

   // negative breakpoint always counts as passed
   assign passed   = bp_rd_ff[DATA_W-1] || (elapsed_ff > bp_rd_ff);
   assign seg_next = ((seg_ff < count_eff) && passed) ? seg_ff + SW'(1) : seg_ff;

   assign bp_wr = req_accept && (req_mode == MODE_LOAD_B)
                  && (32'(req_table_index) < MAX_BREAKPOINTS);
   assign x_wr  = req_accept && (req_mode == MODE_LOAD_X)
                  && (32'(req_table_index) < COEF_DEPTH);
   assign y_wr  = req_accept && (req_mode == MODE_LOAD_Y)
                  && (32'(req_table_index) < COEF_DEPTH);

   assign coef_rd_addr = {seg_used_ff, coef_k_ff};

   always_ff @(posedge clock) begin
      if (bp_wr) begin
         bp_mem[SIW'(req_table_index)] <= req_table_value;
      end
      if (x_wr) begin
         x_mem[CAW'(req_table_index)] <= req_table_value;
      end
      if (y_wr) begin
         y_mem[CAW'(req_table_index)] <= req_table_value;
      end
      bp_rd_ff <= bp_mem[seg_ff[SIW-1:0]];
      x_rd_ff  <= x_mem[coef_rd_addr];
      y_rd_ff  <= y_mem[coef_rd_addr];
   end

   assign coef = axis_ff ? y_rd_ff : x_rd_ff;

   // Horner steps per axis, position and velocity interleaved
   always_comb begin
      step_is_v  = 1'b0;
      step_last  = 1'b0;
      step_nxt   = STEP_PB;
      coef_k_nxt = 2'd1;
      unique case (step_ff)
         STEP_PB: begin
            step_nxt   = STEP_VB;
            coef_k_nxt = 2'd1;
         end
         STEP_VB: begin
            step_is_v  = 1'b1;
            step_nxt   = STEP_PC;
            coef_k_nxt = 2'd2;
         end
         STEP_PC: begin
            step_nxt   = STEP_VC;
            coef_k_nxt = 2'd2;
         end
         STEP_VC: begin
            step_is_v  = 1'b1;
            step_nxt   = STEP_PD;
            coef_k_nxt = 2'd3;
         end
         STEP_PD: begin
            step_last  = 1'b1;
         end
         default: begin
            step_last  = 1'b1;
         end
      endcase
   end

   assign mac_operand = step_is_v ? v_ff : p_ff;
   // velocity takes twice the second coefficient
   assign mac_addend  = (step_ff == STEP_VB) ? {coef, 1'b0} : {coef[DATA_W-1], coef};
   assign three_a     = sat_to_32({{(DATA_W){coef[DATA_W-1]}}, coef, 1'b0}
                                  + {{(DATA_W+1){coef[DATA_W-1]}}, coef});

   pcsg_mac #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_mac (
      .clock      (clock),
      .mul_en     (state_ff == S_MUL),
      .operand    (mac_operand),
      .time_value (elapsed_ff),
      .addend     (mac_addend),
      .result     (mac_result)
   );

   always_comb begin
      state_in     = state_ff;
      elapsed_in   = elapsed_ff;
      armed_in     = armed_ff;
      seg_in       = seg_ff;
      seg_used_in  = seg_used_ff;
      coef_k_in    = coef_k_ff;
      step_in      = step_ff;
      axis_in      = axis_ff;
      p_in         = p_ff;
      v_in         = v_ff;
      hold_px_in   = hold_px_ff;
      hold_vx_in   = hold_vx_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      tick_step_in = (csr_write && (csr_index == CSR_TICK_STEP)) ? csr_wdata : tick_step_ff;
      bp_count_in  = (csr_write && (csr_index == CSR_BP_COUNT))
                     ? csr_wdata[COUNT_W-1:0] : bp_count_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               if (req_mode == MODE_START) begin
                  elapsed_in = '0;
                  seg_in     = '0;
                  armed_in   = 1'b1;
               end else if ((req_mode == MODE_TICK) && armed_ff) begin
                  elapsed_in = elapsed_tick;
                  state_in   = S_CMP;
               end
            end
         end
         S_CMP: begin
            if (seg_next >= count_eff) begin
               // wrap past the last breakpoint, no transfer
               seg_in     = '0;
               elapsed_in = '0;
               state_in   = S_IDLE;
            end else if (seg_next == '0) begin
               state_in   = S_IDLE;
            end else begin
               seg_in      = seg_next;
               seg_used_in = SIW'(seg_next - SW'(1));
               axis_in     = 1'b0;
               coef_k_in   = 2'd0;
               state_in    = S_INIT;
            end
         end
         S_INIT: begin
            state_in = S_LOADA;
         end
         S_LOADA: begin
            p_in      = coef;
            v_in      = three_a;
            coef_k_in = 2'd1;
            step_in   = STEP_PB;
            state_in  = S_MUL;
         end
         S_MUL: begin
            state_in = S_ACC;
         end
         S_ACC: begin
            if (step_is_v) begin
               v_in = mac_result;
            end else begin
               p_in = mac_result;
            end
            if (!step_last) begin
               step_in   = step_nxt;
               coef_k_in = coef_k_nxt;
               state_in  = S_MUL;
            end else if (!axis_ff) begin
               hold_px_in = mac_result;
               hold_vx_in = v_ff;
               axis_in    = 1'b1;
               coef_k_in  = 2'd0;
               state_in   = S_INIT;
            end else begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         tick_step_ff <= TICK_RESET;
         bp_count_ff  <= COUNT_W'(1);
         elapsed_ff   <= '0;
         armed_ff     <= 1'b0;
         seg_ff       <= '0;
         seg_used_ff  <= '0;
         coef_k_ff    <= '0;
         step_ff      <= STEP_PB;
         axis_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tick_step_ff <= tick_step_in;
         bp_count_ff  <= bp_count_in;
         elapsed_ff   <= elapsed_in;
         armed_ff     <= armed_in;
         seg_ff       <= seg_in;
         seg_used_ff  <= seg_used_in;
         coef_k_ff    <= coef_k_in;
         step_ff      <= step_in;
         axis_ff      <= axis_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ff       <= p_in;
      v_ff       <= v_in;
      hold_px_ff <= hold_px_in;
      hold_vx_ff <= hold_vx_in;
      if (load_rsp) begin
         rsp_px_ff  <= hold_px_ff;
         rsp_vx_ff  <= hold_vx_ff;
         rsp_py_ff  <= p_ff;
         rsp_vy_ff  <= v_ff;
         rsp_seg_ff <= seg_used_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_position_x   = rsp_px_ff;
   assign rsp_velocity_x   = rsp_vx_ff;
   assign rsp_position_y   = rsp_py_ff;
   assign rsp_velocity_y   = rsp_vy_ff;
   assign rsp_segment_used = SEG_OUT_W'(rsp_seg_ff);

`ifndef SYNTHESIS
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_OUT))
      else $error("result transfer raised outside the output state");

   a_seg_bound: assert property (@(posedge clock) disable iff (reset)
      32'(seg_ff) <= MAX_BREAKPOINTS)
      else $error("segment index beyond breakpoint store");

   a_cmp_armed: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CMP) |-> armed_ff)
      else $error("breakpoint compare while not armed");

   a_y_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ACC && step_ff == STEP_PD && axis_ff) |=> (state_ff == S_OUT))
      else $error("y evaluation did not reach the output state");
`endif

endmodule
`default_nettype wire
